### rtl/ltis_pkg.sv
// Shared types and constants for the lockstep turn input synchronizer.
`default_nettype none

package ltis_pkg;

	localparam int TURN_W     = 31;
	localparam int TICKS_W    = 32;
	localparam int COORD_W    = 10;
	localparam int KEYS_W     = 24;
	localparam int KIND_W     = 3;
	localparam int ACTION_W   = 2;
	localparam int PIDX_W     = 2;
	localparam int CNT_W      = 3;
	localparam int TPT_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// odd key bits are the clicked flags
	localparam logic [KEYS_W-1:0] CLICK_MASK = 24'hAAAAAA;

	localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RECV  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

	localparam logic [KIND_W-1:0] KIND_STALL  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INPUTS = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MSG    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DROP   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_INDEX    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_TURN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NETWORK_ACTIVE = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [KEYS_W-1:0]  keys;
	} inputs_t;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_RECV,
		CMD_TICK
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t             op;
		logic [PIDX_W-1:0]   sender;
		logic [TURN_W-1:0]   turn;
		inputs_t             data;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0]  player_count;
		logic [PIDX_W-1:0] local_index;
		logic [TPT_W-1:0]  ticks_per_turn;
		logic              network_active;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [PIDX_W-1:0]  player;
		logic [TURN_W-1:0]  turn;
		inputs_t            data;
		logic [TICKS_W-1:0] tick_count;
		logic               last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_TURN,
		ST_MSG,
		ST_REPORT
	} seq_state_t;

endpackage

`default_nettype wire

### rtl/ltis_front.sv
// Front end: takes requests, decodes the action and hands commands to the queue.
`default_nettype none

module ltis_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [ltis_pkg::ACTION_W-1:0]   action,
	input  logic [ltis_pkg::PIDX_W-1:0]     sender_index,
	input  logic [ltis_pkg::TURN_W-1:0]     turn_number,
	input  logic [ltis_pkg::COORD_W-1:0]    touch_x,
	input  logic [ltis_pkg::COORD_W-1:0]    touch_y,
	input  logic [ltis_pkg::KEYS_W-1:0]     keys,
	output logic                            cmd_valid,
	output ltis_pkg::cmd_t                  cmd,
	input  logic                            cmd_ready
);
	import ltis_pkg::*;

	logic    vld_s1;
	cmd_t    cmd_s1;
	logic    known;
	cmd_op_t op;

	always_comb begin
		known = 1'b1;
		op    = CMD_TICK;
		case (action)
			ACT_START: op = CMD_START;
			ACT_RECV:  op = CMD_RECV;
			ACT_TICK:  op = CMD_TICK;
			default:   known = 1'b0;
		endcase
	end

	assign req_ready = !vld_s1 || cmd_ready;

	// unknown action codes are taken and dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid && known;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1.op     <= op;
			cmd_s1.sender <= sender_index;
			cmd_s1.turn   <= turn_number;
			cmd_s1.data   <= '{x: touch_x, y: touch_y, keys: keys};
		end
	end

	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

endmodule

`default_nettype wire

### rtl/ltis_queue.sv
// Short command queue decoupling the front end from the sequencer.
`default_nettype none

module ltis_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ltis_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ltis_pkg::cmd_t pop_data
);
	import ltis_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### rtl/ltis_back.sv
// Back end sequencer: turn state, slot rings, player walk and the result register.
`default_nettype none

module ltis_back #(
	parameter int MAX_PLAYERS = 4,
	parameter int RING_DEPTH  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ltis_pkg::cfg_t    cfg,
	input  logic              cmd_valid,
	input  ltis_pkg::cmd_t    cmd,
	output logic              cmd_ready,
	output logic              rsp_valid,
	output ltis_pkg::result_t rsp,
	input  logic              rsp_ready
);
	import ltis_pkg::*;

	localparam int PW      = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
	localparam int NW      = $clog2(MAX_PLAYERS + 1);
	localparam int SW      = $clog2(RING_DEPTH);
	localparam int ENTRIES = MAX_PLAYERS * RING_DEPTH;
	localparam int AW      = $clog2(ENTRIES);
	localparam int CMPW    = (NW > PIDX_W) ? NW : PIDX_W;

	seq_state_t state_q, state_d;

	logic                                 running_q;
	logic [TURN_W-1:0]                    lt_q;
	logic [SW-1:0]                        lt_slot_q;
	logic [TPT_W-1:0]                     tit_q;
	logic [TICKS_W-1:0]                   ticks_q;
	logic [MAX_PLAYERS-1:0][RING_DEPTH-1:0] ready_q;
	logic [MAX_PLAYERS-1:0]               fresh_q;
	logic [NW-1:0]                        p_q;
	inputs_t                              cur_q [MAX_PLAYERS];
	inputs_t                              hold_q;
	result_t                              out_q;
	logic                                 out_valid_q;

	inputs_t                              mem [ENTRIES];
	inputs_t                              rd_q;

	logic [NW-1:0]     n_act;
	logic [PW-1:0]     p_idx;
	logic              last_p;
	logic              all_ready;
	logic              out_free;
	logic              tick_stall;
	logic              tick_inturn;
	logic [TURN_W-1:0] turn_gap;
	logic [TURN_W:0]   turn_sum;
	logic [SW:0]       slot_sum;
	logic [SW-1:0]     recv_slot;
	logic              recv_ok;
	logic [PW-1:0]     sender_idx;
	logic [SW-1:0]     slot_nxt;
	logic              li_ok;
	logic [PW-1:0]     li_idx;

	logic              emit;
	result_t           res;
	logic              do_start;
	logic              do_recv;
	logic              do_step;
	logic              do_load;
	logic              do_turn;
	logic              p_clr;
	logic              p_inc;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;
	inputs_t           mem_wdata;

	// effective player count
	always_comb begin
		if (cfg.player_count < MAX_PLAYERS) begin
			n_act = NW'(cfg.player_count);
		end else begin
			n_act = NW'(MAX_PLAYERS);
		end
	end

	assign p_idx    = p_q[PW-1:0];
	assign last_p   = p_q == (n_act - NW'(1));
	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		all_ready = 1'b1;
		for (int i = 0; i < MAX_PLAYERS; i++) begin
			if ((NW'(i) < n_act) && !ready_q[i][lt_slot_q]) begin
				all_ready = 1'b0;
			end
		end
	end

	assign tick_stall  = !running_q || ((tit_q >= cfg.ticks_per_turn) && !all_ready);
	assign tick_inturn = tit_q < cfg.ticks_per_turn;

	// receive window and slot: slot of the received turn is derived from the
	// current slot plus distance; past the counter wrap the turn is below the depth
	assign turn_gap   = cmd.turn - lt_q;
	assign turn_sum   = {1'b0, lt_q} + {1'b0, turn_gap};
	assign slot_sum   = (SW+1)'(lt_slot_q) + (SW+1)'(turn_gap[SW-1:0]);
	assign sender_idx = PW'(cmd.sender);
	assign recv_ok    = (turn_gap < TURN_W'(RING_DEPTH)) && (CMPW'(cmd.sender) < CMPW'(n_act));

	always_comb begin
		if (turn_sum[TURN_W]) begin
			recv_slot = cmd.turn[SW-1:0];
		end else if (slot_sum >= (SW+1)'(RING_DEPTH)) begin
			recv_slot = SW'(slot_sum - (SW+1)'(RING_DEPTH));
		end else begin
			recv_slot = slot_sum[SW-1:0];
		end
	end

	// slot of the next turn; the turn counter wrap restarts the ring at zero
	always_comb begin
		if (&lt_q) begin
			slot_nxt = '0;
		end else if (lt_slot_q == SW'(RING_DEPTH - 1)) begin
			slot_nxt = '0;
		end else begin
			slot_nxt = lt_slot_q + SW'(1);
		end
	end

	assign li_ok  = CMPW'(cfg.local_index) < CMPW'(MAX_PLAYERS);
	assign li_idx = PW'(cfg.local_index);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && (cmd.op == CMD_TICK) && !tick_stall) begin
					if (tick_inturn) begin
						state_d = (n_act != '0) ? ST_REPORT : ST_IDLE;
					end else begin
						state_d = (n_act != '0) ? ST_LD_RD : ST_TURN;
					end
				end
			end
			ST_LD_RD: state_d = ST_LD_WR;
			ST_LD_WR: state_d = last_p ? ST_TURN : ST_LD_RD;
			ST_TURN: begin
				if (cfg.network_active) begin
					state_d = ST_MSG;
				end else begin
					state_d = (n_act != '0) ? ST_REPORT : ST_IDLE;
				end
			end
			ST_MSG: begin
				if (out_free) begin
					state_d = (n_act != '0) ? ST_REPORT : ST_IDLE;
				end
			end
			ST_REPORT: begin
				if (out_free && last_p) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd_ready = 1'b0;
		emit      = 1'b0;
		res       = '0;
		do_start  = 1'b0;
		do_recv   = 1'b0;
		do_step   = 1'b0;
		do_load   = 1'b0;
		do_turn   = 1'b0;
		p_clr     = 1'b0;
		p_inc     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						CMD_START: begin
							cmd_ready = 1'b1;
							do_start  = 1'b1;
						end
						CMD_RECV: begin
							if (out_free) begin
								cmd_ready      = 1'b1;
								emit           = 1'b1;
								do_recv        = recv_ok;
								res.kind       = recv_ok ? KIND_ACCEPT : KIND_DROP;
								res.player     = cmd.sender;
								res.turn       = cmd.turn;
								res.data       = cmd.data;
								res.tick_count = ticks_q;
								res.last       = 1'b1;
							end
						end
						CMD_TICK: begin
							if (tick_stall) begin
								if (out_free) begin
									cmd_ready      = 1'b1;
									emit           = 1'b1;
									res.kind       = KIND_STALL;
									res.turn       = lt_q;
									res.tick_count = ticks_q;
									res.last       = 1'b1;
								end
							end else begin
								cmd_ready = 1'b1;
								p_clr     = 1'b1;
								do_step   = tick_inturn;
							end
						end
						default: ;
					endcase
				end
			end
			ST_LD_RD: ;
			ST_LD_WR: begin
				do_load = 1'b1;
				p_inc   = !last_p;
				p_clr   = last_p;
			end
			ST_TURN: begin
				do_turn = 1'b1;
				p_clr   = 1'b1;
			end
			ST_MSG: begin
				if (out_free) begin
					emit           = 1'b1;
					res.kind       = KIND_MSG;
					res.player     = cfg.local_index;
					res.turn       = lt_q;
					res.data       = hold_q;
					res.tick_count = ticks_q;
					res.last       = n_act == '0;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					emit           = 1'b1;
					p_inc          = 1'b1;
					res.kind       = KIND_INPUTS;
					res.player     = PIDX_W'(p_q);
					res.turn       = lt_q;
					res.data       = cur_q[p_idx];
					res.tick_count = ticks_q;
					res.last       = last_p;
				end
			end
			default: ;
		endcase
	end

	// slot store ports
	assign mem_raddr = AW'(AW'(p_idx) * AW'(RING_DEPTH) + AW'(lt_slot_q));
	assign mem_we    = do_recv || (do_turn && li_ok);
	assign mem_waddr = do_turn ? AW'(AW'(li_idx) * AW'(RING_DEPTH) + AW'(slot_nxt))
	                           : AW'(AW'(sender_idx) * AW'(RING_DEPTH) + AW'(recv_slot));
	assign mem_wdata = do_turn ? hold_q : cmd.data;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			lt_q        <= '0;
			lt_slot_q   <= '0;
			tit_q       <= TPT_W'(1);
			ticks_q     <= '0;
			ready_q     <= '0;
			fresh_q     <= '0;
			p_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (p_clr) begin
				p_q <= '0;
			end else if (p_inc) begin
				p_q <= p_q + NW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_start) begin
				running_q <= 1'b1;
				lt_q      <= '0;
				lt_slot_q <= '0;
				tit_q     <= '0;
				ticks_q   <= '0;
				fresh_q   <= '1;
				for (int i = 0; i < MAX_PLAYERS; i++) begin
					ready_q[i] <= RING_DEPTH'(1);
				end
			end
			if (do_recv) begin
				ready_q[sender_idx][recv_slot] <= 1'b1;
				if (recv_slot == '0) begin
					fresh_q[sender_idx] <= 1'b0;
				end
			end
			if (do_step) begin
				tit_q   <= tit_q + TPT_W'(1);
				ticks_q <= ticks_q + TICKS_W'(1);
			end
			if (do_load) begin
				ready_q[p_idx][lt_slot_q] <= 1'b0;
			end
			if (do_turn) begin
				lt_q      <= lt_q + TURN_W'(1);
				lt_slot_q <= slot_nxt;
				tit_q     <= TPT_W'(1);
				ticks_q   <= ticks_q + TICKS_W'(1);
				if (li_ok) begin
					ready_q[li_idx][slot_nxt] <= 1'b1;
					if (slot_nxt == '0) begin
						fresh_q[li_idx] <= 1'b0;
					end
				end
			end
		end
	end

	// slot 0 is ready at start with zero inputs until first written
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
		if (cmd_valid && cmd_ready) begin
			hold_q <= cmd.data;
		end
		if (do_start) begin
			for (int i = 0; i < MAX_PLAYERS; i++) begin
				cur_q[i] <= '0;
			end
		end
		if (do_step) begin
			for (int i = 0; i < MAX_PLAYERS; i++) begin
				if (NW'(i) < n_act) begin
					cur_q[i].keys <= cur_q[i].keys & ~CLICK_MASK;
				end
			end
		end
		if (do_load) begin
			cur_q[p_idx] <= (fresh_q[p_idx] && (lt_slot_q == '0)) ? '0 : rd_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

### rtl/lockstep_turn_input_sync.sv
// Top level of the lockstep turn input synchronizer: config registers, front, queue, sequencer.
// A request passes through the front register and then the queue before it reaches the sequencer.
// Start, receive and stalled ticks are handled in the idle state; a tick inside a turn reports each
// active player, and a turn-changing tick loads each player's slot (one store read per player),
// advances the turn, sends the local inputs when sending is on, then reports each player.
// Reset clears all control state and config to defaults; the session is not running until start.
`default_nettype none

module lockstep_turn_input_sync #(
	parameter int MAX_PLAYERS = 4,
	parameter int RING_DEPTH  = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// request channel
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [ltis_pkg::ACTION_W-1:0]     action,
	input  logic [ltis_pkg::PIDX_W-1:0]       sender_index,
	input  logic [ltis_pkg::TURN_W-1:0]       turn_number,
	input  logic [ltis_pkg::COORD_W-1:0]      touch_x,
	input  logic [ltis_pkg::COORD_W-1:0]      touch_y,
	input  logic [ltis_pkg::KEYS_W-1:0]       keys,

	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ltis_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ltis_pkg::CFG_DATA_W-1:0]   cfg_data,

	// result channel
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [ltis_pkg::KIND_W-1:0]       kind,
	output logic [ltis_pkg::PIDX_W-1:0]       player,
	output logic [ltis_pkg::TURN_W-1:0]       turn,
	output logic [ltis_pkg::COORD_W-1:0]      out_touch_x,
	output logic [ltis_pkg::COORD_W-1:0]      out_touch_y,
	output logic [ltis_pkg::KEYS_W-1:0]       out_keys,
	output logic [ltis_pkg::TICKS_W-1:0]      tick_count,
	output logic                              last
);
	import ltis_pkg::*;

	cfg_t    cfg_q;
	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_ready;
	logic    q_valid;
	cmd_t    q_cmd;
	logic    q_ready;
	result_t rsp;

	// config writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.player_count   <= CNT_W'(1);
			cfg_q.local_index    <= '0;
			cfg_q.ticks_per_turn <= TPT_W'(3);
			cfg_q.network_active <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PLAYER_COUNT:   cfg_q.player_count   <= cfg_data[CNT_W-1:0];
				REG_LOCAL_INDEX:    cfg_q.local_index    <= cfg_data[PIDX_W-1:0];
				REG_TICKS_PER_TURN: cfg_q.ticks_per_turn <= cfg_data[TPT_W-1:0];
				REG_NETWORK_ACTIVE: cfg_q.network_active <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// decode and register each request
	ltis_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.action       (action),
		.sender_index (sender_index),
		.turn_number  (turn_number),
		.touch_x      (touch_x),
		.touch_y      (touch_y),
		.keys         (keys),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_ready    (cmd_ready)
	);

	// lets the front keep taking requests while the sequencer walks players
	ltis_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cmd_valid),
		.push_ready (cmd_ready),
		.push_data  (cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_cmd)
	);

	// turn state, slot rings and result register
	ltis_back #(
		.MAX_PLAYERS (MAX_PLAYERS),
		.RING_DEPTH  (RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_ready (q_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_ready (rsp_ready)
	);

	assign kind        = rsp.kind;
	assign player      = rsp.player;
	assign turn        = rsp.turn;
	assign out_touch_x = rsp.data.x;
	assign out_touch_y = rsp.data.y;
	assign out_keys    = rsp.data.keys;
	assign tick_count  = rsp.tick_count;
	assign last        = rsp.last;

endmodule

`default_nettype wire

### sim/lockstep_turn_input_sync_tb.sv
// Self-checking testbench for the lockstep turn input synchronizer.
`timescale 1ns / 100ps

module lockstep_turn_input_sync_tb;
	import ltis_pkg::*;

	localparam int NUM_PLAYERS    = 4;
	localparam int RING_SLOTS     = 4;
	// worst request is a turn change with a send
	localparam int DRAIN_CYCLES   = 48;
	localparam int WATCHDOG_LIMIT = 4000;

	// no package name for the fourth action code; the block must ignore it
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	// Golden model of the turn sync plus the queue of results it predicts.
	class turn_sync_scoreboard;
		logic [CNT_W-1:0]   player_count;
		logic [PIDX_W-1:0]  local_index;
		logic [TPT_W-1:0]   ticks_per_turn;
		logic               network_active;

		bit                 running;
		logic [TURN_W-1:0]  local_turn;
		logic [TPT_W-1:0]   ticks_in_turn;
		logic [TICKS_W-1:0] ticks_done;
		bit                 slot_ready [NUM_PLAYERS*RING_SLOTS];
		inputs_t            slot_inputs [NUM_PLAYERS*RING_SLOTS];
		inputs_t            cur_inputs [NUM_PLAYERS];

		result_t            pending_results [$];
		int                 errors;
		int                 act_hits [4];
		int                 kind_hits [5];
		int                 cfg_writes;

		function new();
			player_count   = 3'd1;
			local_index    = 2'd0;
			ticks_per_turn = 8'd3;
			network_active = 1'b0;
			running        = 1'b0;
			local_turn     = '0;
			ticks_in_turn  = 8'd1;
			ticks_done     = '0;
			foreach (slot_ready[i]) begin
				slot_ready[i]  = 1'b0;
				slot_inputs[i] = '0;
			end
			foreach (cur_inputs[i])
				cur_inputs[i] = '0;
		endfunction

		function int active_players();
			return (int'(player_count) < NUM_PLAYERS) ? int'(player_count) : NUM_PLAYERS;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			cfg_writes++;
			case (idx)
				REG_PLAYER_COUNT:   player_count   = data[CNT_W-1:0];
				REG_LOCAL_INDEX:    local_index    = data[PIDX_W-1:0];
				REG_TICKS_PER_TURN: ticks_per_turn = data[TPT_W-1:0];
				REG_NETWORK_ACTIVE: network_active = data[0];
				default: ;
			endcase
		endfunction

		// tick_count always carries the tick total as it stands after the update
		function result_t make_result(logic [KIND_W-1:0] k, logic [PIDX_W-1:0] p,
				logic [TURN_W-1:0] t, inputs_t d);
			result_t r;
			r.kind       = k;
			r.player     = p;
			r.turn       = t;
			r.data       = d;
			r.tick_count = ticks_done;
			r.last       = 1'b0;
			return r;
		endfunction

		function void note_request(logic [ACTION_W-1:0] act, logic [PIDX_W-1:0] snd,
				logic [TURN_W-1:0] tn, inputs_t din);
			result_t           burst [$];
			logic [TURN_W-1:0] turn_gap;
			bit                ok;
			bit                stalled;
			int                n;
			int                s;
			int                d;

			n = active_players();
			act_hits[act]++;
			case (act)
				ACT_START: begin
					foreach (slot_ready[i]) begin
						slot_ready[i]  = 1'b0;
						slot_inputs[i] = '0;
					end
					foreach (cur_inputs[i])
						cur_inputs[i] = '0;
					for (int p = 0; p < NUM_PLAYERS; p++)
						slot_ready[p*RING_SLOTS] = 1'b1;
					local_turn    = '0;
					ticks_done    = '0;
					ticks_in_turn = '0;
					running       = 1'b1;
				end
				ACT_RECV: begin
					// window distance wraps with the 31-bit turn counter
					turn_gap = tn - local_turn;
					ok = (turn_gap < RING_SLOTS) && (int'(snd) < n);
					if (ok) begin
						s = int'(snd) * RING_SLOTS + int'(tn % RING_SLOTS);
						slot_inputs[s] = din;
						slot_ready[s]  = 1'b1;
					end
					burst.push_back(make_result(ok ? KIND_ACCEPT : KIND_DROP, snd, tn, din));
				end
				ACT_TICK: begin
					stalled = !running;
					s = int'(local_turn % RING_SLOTS);
					// turn boundary: every active player must have its slot filled
					if (running && ticks_in_turn >= ticks_per_turn)
						for (int p = 0; p < n; p++)
							if (!slot_ready[p*RING_SLOTS + s])
								stalled = 1'b1;
					if (stalled) begin
						burst.push_back(make_result(KIND_STALL, '0, local_turn, '0));
					end else begin
						if (ticks_in_turn < ticks_per_turn) begin
							ticks_in_turn = ticks_in_turn + 8'd1;
							for (int p = 0; p < n; p++)
								cur_inputs[p].keys = cur_inputs[p].keys & ~CLICK_MASK;
						end else begin
							for (int p = 0; p < n; p++) begin
								cur_inputs[p] = slot_inputs[p*RING_SLOTS + s];
								slot_ready[p*RING_SLOTS + s] = 1'b0;
							end
							local_turn    = local_turn + 31'd1;
							ticks_in_turn = 8'd1;
							if (int'(local_index) < NUM_PLAYERS) begin
								d = int'(local_index) * RING_SLOTS + int'(local_turn % RING_SLOTS);
								slot_inputs[d] = din;
								slot_ready[d]  = 1'b1;
							end
						end
						ticks_done = ticks_done + 32'd1;
						if (ticks_in_turn == 8'd1 && network_active && s != int'(local_turn % RING_SLOTS))
							burst.push_back(make_result(KIND_MSG, local_index, local_turn, din));
						for (int p = 0; p < n; p++)
							burst.push_back(make_result(KIND_INPUTS, p[PIDX_W-1:0], local_turn,
								cur_inputs[p]));
					end
				end
				default: ;
			endcase
			if (burst.size() > 0)
				burst[burst.size()-1].last = 1'b1;
			foreach (burst[i])
				pending_results.push_back(burst[i]);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] exp);
			$display("ERROR %0t: %s got %0h expected %0h", $time, what, got, exp);
			errors++;
		endtask

		task check_result(result_t got);
			result_t exp;
			if (pending_results.size() == 0) begin
				report("result with nothing outstanding, kind", 32'(got.kind), 32'd0);
			end else begin
				exp = pending_results.pop_front();
				kind_hits[exp.kind]++;
				if (got.kind !== exp.kind)             report("kind", 32'(got.kind), 32'(exp.kind));
				if (got.player !== exp.player)         report("player", 32'(got.player), 32'(exp.player));
				if (got.turn !== exp.turn)             report("turn", 32'(got.turn), 32'(exp.turn));
				if (got.data.x !== exp.data.x)         report("out_touch_x", 32'(got.data.x),
					32'(exp.data.x));
				if (got.data.y !== exp.data.y)         report("out_touch_y", 32'(got.data.y),
					32'(exp.data.y));
				if (got.data.keys !== exp.data.keys)   report("out_keys", 32'(got.data.keys),
					32'(exp.data.keys));
				if (got.tick_count !== exp.tick_count) report("tick_count", got.tick_count,
					exp.tick_count);
				if (got.last !== exp.last)             report("last", 32'(got.last), 32'(exp.last));
			end
		endtask
	endclass

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;

	logic                  req_valid    = 1'b0;
	logic                  req_ready;
	logic [ACTION_W-1:0]   action       = '0;
	logic [PIDX_W-1:0]     sender_index = '0;
	logic [TURN_W-1:0]     turn_number  = '0;
	logic [COORD_W-1:0]    touch_x      = '0;
	logic [COORD_W-1:0]    touch_y      = '0;
	logic [KEYS_W-1:0]     keys         = '0;

	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	logic                  rsp_valid;
	logic                  rsp_ready    = 1'b0;
	logic [KIND_W-1:0]     kind;
	logic [PIDX_W-1:0]     player;
	logic [TURN_W-1:0]     turn;
	logic [COORD_W-1:0]    out_touch_x;
	logic [COORD_W-1:0]    out_touch_y;
	logic [KEYS_W-1:0]     out_keys;
	logic [TICKS_W-1:0]    tick_count;
	logic                  last;

	turn_sync_scoreboard sb = new();

	// idle odds in percent per cycle; swapped between sender and receiver mid-run
	int send_idle_pct = 32;
	int rsp_idle_pct  = 73;
	int sent_count    = 0;
	int idle_cycles   = 0;

	lockstep_turn_input_sync #(
		.MAX_PLAYERS (NUM_PLAYERS),
		.RING_DEPTH  (RING_SLOTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.action       (action),
		.sender_index (sender_index),
		.turn_number  (turn_number),
		.touch_x      (touch_x),
		.touch_y      (touch_y),
		.keys         (keys),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.kind         (kind),
		.player       (player),
		.turn         (turn),
		.out_touch_x  (out_touch_x),
		.out_touch_y  (out_touch_y),
		.out_keys     (out_keys),
		.tick_count   (tick_count),
		.last         (last)
	);

	always #4 clk = ~clk;

	// Result side: sample at the edge, so the values seen are those of the
	// cycle just ended; ready is redrawn every cycle.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result({kind, player, turn, out_touch_x, out_touch_y, out_keys,
				tick_count, last});
		rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, sb.pending_results.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// One request. Valid stays high from one request to the next unless an
	// idle gap is drawn, so it is never lowered and raised in the same step.
	task automatic send_request(logic [ACTION_W-1:0] act, logic [PIDX_W-1:0] snd,
			logic [TURN_W-1:0] tn, inputs_t din);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		action       <= act;
		sender_index <= snd;
		turn_number  <= tn;
		touch_x      <= din.x;
		touch_y      <= din.y;
		keys         <= din.keys;
		do @(posedge clk); while (!req_ready);
		sb.note_request(act, snd, tn, din);
		sent_count++;
		// receiver-heavy gaps first, then sender-heavy, then full rate
		if (sent_count < 41) begin
			send_idle_pct = 32;
			rsp_idle_pct  = 73;
		end else if (sent_count < 82) begin
			send_idle_pct = 73;
			rsp_idle_pct  = 32;
		end else begin
			send_idle_pct = 0;
			rsp_idle_pct  = 0;
		end
	endtask

	// Drain: every predicted result in, then enough quiet cycles for a
	// request that produces nothing to clear the pipeline.
	task automatic settle_block();
		req_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high between back-to-back writes.
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic write_config(logic [CNT_W-1:0] pc, logic [PIDX_W-1:0] li,
			logic [TPT_W-1:0] tpt, logic nw);
		cfg_write(REG_PLAYER_COUNT, 8'(pc));
		cfg_write(REG_LOCAL_INDEX, 8'(li));
		cfg_write(REG_TICKS_PER_TURN, tpt);
		cfg_write(REG_NETWORK_ACTIVE, 8'(nw));
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed traffic: ticks plus remote inputs aimed at the
	// current or next few turns so sessions keep advancing; the rest is noise.
	task automatic run_random_phase(logic [CNT_W-1:0] pc, logic [PIDX_W-1:0] li,
			logic [TPT_W-1:0] tpt, logic nw, int count);
		logic [ACTION_W-1:0] act;
		logic [PIDX_W-1:0]   snd;
		logic [TURN_W-1:0]   tn;
		inputs_t             d;
		int                  r;
		int                  n;
		int                  pick;

		settle_block();
		write_config(pc, li, tpt, nw);
		send_request(ACT_START, '0, '0, '0);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 6) begin
				// hold back until the block has answered everything
				req_valid <= 1'b0;
				do @(posedge clk); while (sb.pending_results.size() != 0);
			end
			d.x    = 10'($urandom_range(0, 1023));
			d.y    = 10'($urandom_range(0, 1023));
			d.keys = 24'($urandom_range(0, 24'hFFFFFF));
			snd    = 2'($urandom_range(0, 3));
			tn     = 31'($urandom);
			r      = $urandom_range(0, 99);
			if (r < 40) begin
				act = ACT_TICK;
			end else if (r < 80) begin
				act = ACT_RECV;
				n = sb.active_players();
				if (n > 0) begin
					pick = $urandom_range(0, n - 1);
					if (pick == int'(li) && n > 1)
						pick = (pick + 1) % n;
					snd = 2'(pick);
				end
				r = $urandom_range(0, 99);
				tn = sb.local_turn + 31'((r < 60) ? 0 : (r < 85) ? 1 : $urandom_range(2, 3));
			end else if (r < 83) begin
				act = ACT_START;
			end else begin
				act = 2'($urandom_range(0, 3));
			end
			send_request(act, snd, tn, d);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Reset defaults: one player, three ticks per turn, no sending.
		// Before start a tick stalls but remote inputs are still filed.
		send_request(ACT_TICK, 2'd0, 31'd0, '0);
		send_request(ACT_RECV, 2'd0, 31'd0, '1);
		send_request(ACT_RECV, 2'd3, 31'd0, '1);
		send_request(ACT_UNUSED, 2'd2, 31'h7FFFFFFF, '1);
		send_request(ACT_START, 2'd0, 31'd0, '0);
		repeat (3) send_request(ACT_TICK, 2'd0, 31'd0, '0);
		send_request(ACT_TICK, 2'd1, 31'd5, '{x: 10'd1023, y: 10'd0, keys: 24'hFFFFFF});

		// Two players, local is player 1, two ticks per turn, sending on.
		settle_block();
		write_config(3'd2, 2'd1, 8'd2, 1'b1);
		send_request(ACT_START, 2'd0, 31'd0, '0);
		// just past the window, then a wrapped distance
		send_request(ACT_RECV, 2'd0, 31'd4, '1);
		send_request(ACT_RECV, 2'd0, 31'h7FFFFFFF, '1);
		// remote inputs for turn 1 with every clicked bit set
		send_request(ACT_RECV, 2'd0, 31'd1, '{x: 10'd0, y: 10'd1023, keys: 24'hAAAAAA});
		repeat (2) send_request(ACT_TICK, 2'd0, 31'd0, '0);
		send_request(ACT_TICK, 2'd0, 31'd0, '{x: 10'd512, y: 10'd1, keys: 24'hFFFFFF});
		send_request(ACT_TICK, 2'd0, 31'd0, '0);
		// turn change loads the clicked inputs; the tick after clears them
		send_request(ACT_TICK, 2'd2, 31'd0, '{x: 10'd1, y: 10'd512, keys: 24'h555555});
		send_request(ACT_TICK, 2'd0, 31'd0, '0);
		// player 0 has nothing for turn 2 yet: stall, then fill and go
		send_request(ACT_TICK, 2'd0, 31'd0, '0);
		send_request(ACT_RECV, 2'd0, 31'd2, '{x: 10'd1023, y: 10'd1023, keys: 24'h555555});
		send_request(ACT_TICK, 2'd0, 31'd0, '0);

		// Random phases across register extremes.
		run_random_phase(3'd4, 2'd2, 8'd1, 1'b1, 15);
		run_random_phase(3'd0, 2'd3, 8'd0, 1'b1, 15);   // no players, every tick a turn
		run_random_phase(3'd2, 2'd3, 8'd255, 1'b0, 15); // local index outside the count
		run_random_phase(3'd7, 2'd1, 8'd2, 1'b1, 15);   // count above the player limit
		run_random_phase(3'd3, 2'd0, 8'd5, 1'b0, 15);

		settle_block();
		$display("Covered %0d requests: %0d start, %0d receive, %0d tick, %0d unused code;",
			sent_count, sb.act_hits[0], sb.act_hits[1], sb.act_hits[2], sb.act_hits[3]);
		$display("%0d config writes; checked %0d stalled, %0d reports, %0d sent, %0d accepted, %0d dropped",
			sb.cfg_writes, sb.kind_hits[0], sb.kind_hits[1], sb.kind_hits[2],
			sb.kind_hits[3], sb.kind_hits[4]);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### lockstep_turn_input_sync.f
rtl/ltis_pkg.sv
rtl/ltis_front.sv
rtl/ltis_queue.sv
rtl/ltis_back.sv
rtl/lockstep_turn_input_sync.sv
sim/lockstep_turn_input_sync_tb.sv
